// ===== sv/pcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_pkg
// Constants and types shared by the PCG64 XSL-RR generator modules.
// ----------------------------------------------------------------------------
package pcg_pkg;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned LCG_W    = 128;
   localparam int unsigned LIMB_W   = 32;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 64;

   // register index decoded from paddr[3]
   localparam logic REG_SEED = 1'b0;

   localparam logic [LCG_W-1:0]  LCG_MULT  = 128'h2360ED051FC65DA4_4385DF649FCCF645;
   localparam logic [WORD_W-1:0] MIX_GOLD  = 64'h9E3779B97F4A7C15;
   localparam logic [WORD_W-1:0] MIX_C1    = 64'hBF58476D1CE4E5B9;
   localparam logic [WORD_W-1:0] MIX_C2    = 64'h94D049BB133111EB;
   localparam logic [WORD_W-1:0] SEED_RST  = 64'h0;

   // request to the shared multiply-accumulate unit
   typedef struct packed {
      logic start;   // pulse: latch operands and begin
      logic wide;    // 1: 128-bit product (4 limbs), 0: 64-bit (2 limbs)
   } mul_req_type;

endpackage : pcg_pkg
`default_nettype wire

// ===== sv/pcg_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_req_if / pcg_rsp_if
// Valid/ready channels carrying generator requests and results.
// ----------------------------------------------------------------------------
interface pcg_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [63:0] range_low;
   logic signed [63:0] range_high;
   modport source (output valid, mode, range_low, range_high, input ready);
   modport sink   (input valid, mode, range_low, range_high, output ready);
endinterface : pcg_req_if

interface pcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        range_error;
   modport source (output valid, value, range_error, input ready);
   modport sink   (input valid, value, range_error, output ready);
endinterface : pcg_rsp_if
`default_nettype wire

// ===== sv/pcg_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_mul
// Shared 32x32 multiply-accumulate unit: forms a truncated product
// a * b + init, modulo 2^64 or 2^128, one partial product per cycle.
// ----------------------------------------------------------------------------
module pcg_mul (
   input  wire                        clock,
   input  wire                        reset,
   input  pcg_pkg::mul_req_type       req,
   input  wire [pcg_pkg::LCG_W-1:0]   op_a,
   input  wire [pcg_pkg::LCG_W-1:0]   op_b,
   input  wire [pcg_pkg::LCG_W-1:0]   acc_init,
   output logic                       done,
   output logic [pcg_pkg::LCG_W-1:0]  result
);
   import pcg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 issue_ff, issue_in;
   logic                 pv_ff, pv_in;
   logic                 wide_ff, wide_in;
   logic [1:0]           i_ff, i_in, j_ff, j_in, sh_ff, sh_in;
   logic [2*LIMB_W-1:0]  prod_ff, prod_in;
   logic [LCG_W-1:0]     a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]           top;
   logic [2:0]           ij_sum;
   logic [LCG_W-1:0]     addend;

   assign top    = wide_ff ? 2'd3 : 2'd1;
   assign ij_sum = {1'b0, i_ff} + {1'b0, j_ff};
   assign addend = {{(LCG_W-2*LIMB_W){1'b0}}, prod_ff} << (LIMB_W * sh_ff);
   assign done   = busy_ff && !issue_ff && !pv_ff;
   assign result = acc_ff;

   // pair sequencing: all limb pairs with i+j <= top
   always_comb begin
      busy_in  = busy_ff;
      issue_in = issue_ff;
      pv_in    = 1'b0;
      wide_in  = wide_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      sh_in    = sh_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (pv_ff) begin
         acc_in = acc_ff + addend;
      end
      if (req.start) begin
         busy_in  = 1'b1;
         issue_in = 1'b1;
         wide_in  = req.wide;
         i_in     = 2'd0;
         j_in     = 2'd0;
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = acc_init;
      end else if (issue_ff) begin
         prod_in = {{LIMB_W{1'b0}}, a_ff[LIMB_W*i_ff +: LIMB_W]} *
                   {{LIMB_W{1'b0}}, b_ff[LIMB_W*j_ff +: LIMB_W]};
         sh_in   = ij_sum[1:0];
         pv_in   = 1'b1;
         if (i_ff == top) begin
            issue_in = 1'b0;
         end else if (ij_sum < {1'b0, top}) begin
            j_in = j_ff + 2'd1;
         end else begin
            i_in = i_ff + 2'd1;
            j_in = 2'd0;
         end
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         issue_ff <= issue_in;
         pv_ff    <= pv_in;
      end
      wide_ff <= wide_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      sh_ff   <= sh_in;
      prod_ff <= prod_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
   end

endmodule : pcg_mul
`default_nettype wire

// ===== sv/pcg64_xsl_rr_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg64_xsl_rr_generator_unit
// 128-bit PCG generator with XSL-RR output, raw and bounded-integer draws.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch  : request beat (mode, range_low, range_high), valid/ready.
//  rsp_ch  : result beat (value, range_error), one per request.
//  APB     : register 0 (byte 0) is the 64-bit seed; a write re-derives the
//            LCG state and stream increment (four splitmix64 words).
//  Datapath: all multiplications run through one 32x32 multiply-accumulate
//            unit. An LCG step takes 10 partial products; each rejected
//            bounded draw runs another LCG step. Reversed and single-value
//            ranges return without an LCG step.
//  Seeding : runs after reset or a seed write; ready is low meanwhile.
//  Reset   : synchronous; reseeds with seed 0.
//  Stall   : a finished result is held in the output register; a new request
//            is taken meanwhile, but its result waits until rsp_ch drains.
// ----------------------------------------------------------------------------
module pcg64_xsl_rr_generator_unit (
   input  wire                          clock,
   input  wire                          reset,
   pcg_req_if.sink                      req_ch,
   pcg_rsp_if.source                    rsp_ch,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [pcg_pkg::CSR_AW-1:0]    paddr,
   input  wire [pcg_pkg::CSR_DW-1:0]    pwdata,
   output logic [pcg_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import pcg_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MIX_ADD  = 4'd1;
   localparam logic [3:0] S_MIX_M1   = 4'd2;
   localparam logic [3:0] S_MIX_W1   = 4'd3;
   localparam logic [3:0] S_MIX_M2   = 4'd4;
   localparam logic [3:0] S_MIX_W2   = 4'd5;
   localparam logic [3:0] S_MIX_END  = 4'd6;
   localparam logic [3:0] S_SEED_INC = 4'd7;
   localparam logic [3:0] S_SEED_ADD = 4'd8;
   localparam logic [3:0] S_ADV      = 4'd9;
   localparam logic [3:0] S_ADV_W    = 4'd10;
   localparam logic [3:0] S_PREP     = 4'd11;
   localparam logic [3:0] S_CHECK    = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   logic [3:0]               state_ff, state_in;
   logic [WORD_W-1:0]        seed_ff, seed_in;
   logic [WORD_W-1:0]        x_ff, x_in, z_ff, z_in;
   logic [1:0]               k_ff, k_in;
   logic [WORD_W-1:0]        w_ff [4];
   logic [WORD_W-1:0]        w_in;
   logic                     w_we;
   logic [LCG_W-1:0]         st_ff, st_in, inc_ff, inc_in;
   logic                     seeding_ff, seeding_in;
   logic                     mode_ff, mode_in;
   logic signed [WORD_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_W-1:0]        d_ff, d_in, mask_ff, mask_in;
   logic [WORD_W-1:0]        res_ff, res_in;
   logic                     err_ff, err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_err_ff, rsp_err_in;

   logic                     cfg_wr;
   logic                     req_acc;
   mul_req_type              mreq;
   logic [LCG_W-1:0]         m_a, m_b, m_init, m_res;
   logic                     m_done;
   logic [WORD_W-1:0]        diff, smear, xw, word, vmask;
   logic [6:0]               rot;

   assign pready  = 1'b1;
   assign prdata  = (paddr[3] == REG_SEED) ? seed_ff : '0;
   assign cfg_wr  = psel && penable && pwrite && (paddr[3] == REG_SEED);

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign req_acc        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.value   = rsp_value_ff;
   assign rsp_ch.range_error = rsp_err_ff;

   // bound arithmetic: span - 1 and the smallest covering mask
   always_comb begin
      diff  = hi_ff - lo_ff;
      smear = diff;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
      smear = smear | (smear >> 32);
   end

   // XSL-RR output of the current state
   assign xw    = st_ff[LCG_W-1 -: WORD_W] ^ st_ff[WORD_W-1:0];
   assign rot   = {1'b0, st_ff[LCG_W-1 -: 6]};
   assign word  = (xw >> rot) | (xw << (7'd64 - rot));
   assign vmask = word & mask_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mreq.start = 1'b0;
      mreq.wide  = 1'b0;
      m_a        = '0;
      m_b        = '0;
      m_init     = '0;
      unique case (state_ff)
         S_MIX_M1: begin
            mreq.start = 1'b1;
            m_a = {{(LCG_W-WORD_W){1'b0}}, z_ff ^ (z_ff >> 30)};
            m_b = {{(LCG_W-WORD_W){1'b0}}, MIX_C1};
         end
         S_MIX_M2: begin
            mreq.start = 1'b1;
            m_a = {{(LCG_W-WORD_W){1'b0}}, z_ff ^ (z_ff >> 27)};
            m_b = {{(LCG_W-WORD_W){1'b0}}, MIX_C2};
         end
         S_ADV: begin
            mreq.start = 1'b1;
            mreq.wide  = 1'b1;
            m_a    = st_ff;
            m_b    = LCG_MULT;
            m_init = inc_ff;
         end
         default: begin
         end
      endcase
   end

   pcg_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .req      (mreq),
      .op_a     (m_a),
      .op_b     (m_b),
      .acc_init (m_init),
      .done     (m_done),
      .result   (m_res)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      seed_in    = seed_ff;
      x_in       = x_ff;
      z_in       = z_ff;
      k_in       = k_ff;
      w_in       = z_ff ^ (z_ff >> 31);
      w_we       = 1'b0;
      st_in      = st_ff;
      inc_in     = inc_ff;
      seeding_in = seeding_ff;
      mode_in    = mode_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      d_in       = d_ff;
      mask_in    = mask_ff;
      res_in     = res_ff;
      err_in     = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               mode_in  = req_ch.mode;
               lo_in    = req_ch.range_low;
               hi_in    = req_ch.range_high;
               state_in = S_PREP;
            end
         end
         S_MIX_ADD: begin
            x_in     = x_ff + MIX_GOLD;
            z_in     = x_ff + MIX_GOLD;
            state_in = S_MIX_M1;
         end
         S_MIX_M1: state_in = S_MIX_W1;
         S_MIX_W1: begin
            if (m_done) begin
               z_in     = m_res[WORD_W-1:0];
               state_in = S_MIX_M2;
            end
         end
         S_MIX_M2: state_in = S_MIX_W2;
         S_MIX_W2: begin
            if (m_done) begin
               z_in     = m_res[WORD_W-1:0];
               state_in = S_MIX_END;
            end
         end
         S_MIX_END: begin
            w_we = 1'b1;
            k_in = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? S_SEED_INC : S_MIX_ADD;
         end
         S_SEED_INC: begin
            // first step from a zero state leaves just the increment
            inc_in = {w_ff[2][WORD_W-2:0], w_ff[3], 1'b1};
            st_in  = {w_ff[2][WORD_W-2:0], w_ff[3], 1'b1};
            state_in = S_SEED_ADD;
         end
         S_SEED_ADD: begin
            st_in    = st_ff + {w_ff[0], w_ff[1]};
            state_in = S_ADV;
         end
         S_ADV: state_in = S_ADV_W;
         S_ADV_W: begin
            if (m_done) begin
               st_in = m_res;
               if (seeding_ff) begin
                  seeding_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_PREP: begin
            d_in    = diff;
            mask_in = smear;
            err_in  = 1'b0;
            if (!mode_ff) begin
               state_in = S_ADV;
            end else if (hi_ff < lo_ff) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = S_OUT;
            end else if (diff == '0) begin
               res_in   = lo_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_ADV;
            end
         end
         S_CHECK: begin
            if (!mode_ff) begin
               res_in   = word;
               state_in = S_OUT;
            end else if (&d_ff) begin
               // full 2^64 span: any draw fits
               res_in   = lo_ff + word;
               state_in = S_OUT;
            end else if (vmask <= d_ff) begin
               res_in   = lo_ff + vmask;
               state_in = S_OUT;
            end else begin
               state_in = S_ADV;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // seed write restarts the expansion
      if (cfg_wr) begin
         seed_in    = pwdata;
         x_in       = pwdata;
         k_in       = 2'd0;
         seeding_in = 1'b1;
         state_in   = S_MIX_ADD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_MIX_ADD;
         seed_ff      <= SEED_RST;
         x_ff         <= SEED_RST;
         k_ff         <= 2'd0;
         seeding_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         x_ff         <= x_in;
         k_ff         <= k_in;
         seeding_ff   <= seeding_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      z_ff         <= z_in;
      st_ff        <= st_in;
      inc_ff       <= inc_in;
      mode_ff      <= mode_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      d_ff         <= d_in;
      mask_ff      <= mask_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      if (w_we) begin
         w_ff[k_ff] <= w_in;
      end
   end

endmodule : pcg64_xsl_rr_generator_unit
`default_nettype wire

// ===== sv/pcg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_checker
// Port-level checks for the PCG64 generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcg_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [63:0] rsp_value,
   input wire        rsp_error,
   input wire        cfg_write
);

   // result beat is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == 64'd0)
      else $error("range error with non-zero value");

   // generator reseeds after reset before taking requests
   a_reset_busy: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken before seeding");

   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted back to back");

   // a seed write starts the expansion
   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> !req_ready)
      else $error("ready during seed expansion");

endmodule : pcg_checker

bind pcg64_xsl_rr_generator_unit pcg_checker u_pcg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.value),
   .rsp_error (rsp_ch.range_error),
   .cfg_write (psel && penable && pwrite && !paddr[3])
);
`default_nettype wire
